### rtl/sfr_pkg.sv
// Shared constants, word types and cell control types for the find-and-replace unit.
package sfr_pkg;

    localparam int CP_W            = 21;
    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int WIN_DEPTH       = MAX_PATTERN - 1;
    localparam int FILL_W          = 3;
    localparam int LEN_W           = 4;
    localparam int CNT_W           = 4;
    localparam int OUT_DEPTH       = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 63;
    localparam int CHARS3_W        = 3 * CP_W;
    localparam int CHARS2_W        = 2 * CP_W;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_CHARS_0_2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_CHARS_3_5  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_CHARS_6_7  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_CHARS_0_2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_CHARS_3_5  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_CHARS_6_7  = 3'd7;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            last;
    } in_word_t;

    typedef struct packed {
        logic [CP_W-1:0] out_char;
        logic            has_char;
        logic            end_of_message;
    } out_word_t;

    typedef struct packed {
        logic shift;
        logic take_c;
    } win_ctl_t;

    typedef struct packed {
        logic load;
        logic shift;
    } out_ctl_t;

endpackage

### rtl/substring_find_replace_unit.sv
// Top level: streaming find-and-replace over code points with a row of window and result cells.
//
//  channel  | valid   | ready   | payload | word
//  ---------+---------+---------+---------+----------------------------------------------
//  input    | s_valid | s_ready | s_data  | code_point, last
//  result   | m_valid | m_ready | m_data  | out_char, has_char, end_of_message
//  config   | cfg_wr_en | -     | cfg_wdata | register cfg_index, no wait, no read-back
//
//  An input word is taken when s_valid and s_ready are high; its results (0 to 8 words)
//  are loaded in that same cycle into the result cells and leave one per cycle, while
//  m_ready is high, from the head cell. A new input word is taken while the last pending
//  result leaves, so a stream that yields at most one result per input runs at one word
//  per cycle while m_ready is high; a longer replacement or flush holds the input until its last result leaves.
//  Reset (aresetn low, synchronous) empties the window and the result cells and clears
//  all configuration registers. No clearing pass is needed.
module substring_find_replace_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  sfr_pkg::in_word_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output sfr_pkg::out_word_t              m_data,
    input  logic                            cfg_wr_en,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    // ---------------------------------------------------------------- configuration
    logic [sfr_pkg::LEN_W-1:0]    pat_len_reg;
    logic [sfr_pkg::LEN_W-1:0]    rep_len_reg;
    logic [sfr_pkg::CHARS3_W-1:0] pat_02_reg, pat_35_reg, rep_02_reg, rep_35_reg;
    logic [sfr_pkg::CHARS2_W-1:0] pat_67_reg, rep_67_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_len_reg <= '0;
            rep_len_reg <= '0;
            pat_02_reg  <= '0;
            pat_35_reg  <= '0;
            pat_67_reg  <= '0;
            rep_02_reg  <= '0;
            rep_35_reg  <= '0;
            rep_67_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sfr_pkg::REG_PATTERN_LENGTH:     pat_len_reg <= cfg_wdata[sfr_pkg::LEN_W-1:0];
                sfr_pkg::REG_REPLACEMENT_LENGTH: rep_len_reg <= cfg_wdata[sfr_pkg::LEN_W-1:0];
                sfr_pkg::REG_PATTERN_CHARS_0_2:  pat_02_reg  <= cfg_wdata;
                sfr_pkg::REG_PATTERN_CHARS_3_5:  pat_35_reg  <= cfg_wdata;
                sfr_pkg::REG_PATTERN_CHARS_6_7:  pat_67_reg  <= cfg_wdata[sfr_pkg::CHARS2_W-1:0];
                sfr_pkg::REG_REPLACE_CHARS_0_2:  rep_02_reg  <= cfg_wdata;
                sfr_pkg::REG_REPLACE_CHARS_3_5:  rep_35_reg  <= cfg_wdata;
                sfr_pkg::REG_REPLACE_CHARS_6_7:  rep_67_reg  <= cfg_wdata[sfr_pkg::CHARS2_W-1:0];
            endcase
        end
    end

    // Character 0 sits in the lowest bits, so the three registers line up as one vector.
    logic [sfr_pkg::MAX_PATTERN*sfr_pkg::CP_W-1:0]     pat_all;
    logic [sfr_pkg::MAX_REPLACEMENT*sfr_pkg::CP_W-1:0] rep_all;
    logic [sfr_pkg::CP_W-1:0] pat_chars [sfr_pkg::MAX_PATTERN];
    logic [sfr_pkg::CP_W-1:0] rep_chars [sfr_pkg::MAX_REPLACEMENT];

    assign pat_all = {pat_67_reg, pat_35_reg, pat_02_reg};
    assign rep_all = {rep_67_reg, rep_35_reg, rep_02_reg};

    for (genvar gp = 0; gp < sfr_pkg::MAX_PATTERN; gp++) begin : g_pat
        assign pat_chars[gp] = pat_all[gp*sfr_pkg::CP_W +: sfr_pkg::CP_W];
    end
    for (genvar gr = 0; gr < sfr_pkg::MAX_REPLACEMENT; gr++) begin : g_rep
        assign rep_chars[gr] = rep_all[gr*sfr_pkg::CP_W +: sfr_pkg::CP_W];
    end

    // Saturate lengths above the maximum.
    logic [sfr_pkg::LEN_W-1:0] plen, rlen;
    assign plen = (pat_len_reg > sfr_pkg::LEN_W'(sfr_pkg::MAX_PATTERN))
                  ? sfr_pkg::LEN_W'(sfr_pkg::MAX_PATTERN) : pat_len_reg;
    assign rlen = (rep_len_reg > sfr_pkg::LEN_W'(sfr_pkg::MAX_REPLACEMENT))
                  ? sfr_pkg::LEN_W'(sfr_pkg::MAX_REPLACEMENT) : rep_len_reg;

    // ---------------------------------------------------------------- handshake
    logic [sfr_pkg::CNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic                      s_acc, m_acc;

    // Take a new word when the result cells are empty or their last word leaves now.
    assign m_valid = (out_cnt_reg != '0);
    assign m_acc   = m_valid && m_ready;
    assign s_ready = (out_cnt_reg == '0) ||
                     ((out_cnt_reg == sfr_pkg::CNT_W'(1)) && m_ready);
    assign s_acc   = s_valid && s_ready;

    // ---------------------------------------------------------------- window decision
    logic [sfr_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic [sfr_pkg::LEN_W-1:0]  fill_ext;
    logic [sfr_pkg::CP_W-1:0]   c;
    logic                       last;
    logic [sfr_pkg::CP_W-1:0]   win_chars [sfr_pkg::WIN_DEPTH];
    logic [sfr_pkg::WIN_DEPTH-1:0] win_hit;
    logic [sfr_pkg::WIN_DEPTH-1:0] win_below;
    logic                       pass_all, full, match;
    logic                       do_shift, do_append, use_rep, bare;
    logic [sfr_pkg::CNT_W-1:0]  res_cnt;

    assign c        = s_data.code_point;
    assign last     = s_data.last;
    assign fill_ext = sfr_pkg::LEN_W'(fill_reg);

    for (genvar gb = 0; gb < sfr_pkg::WIN_DEPTH; gb++) begin : g_below
        assign win_below[gb] = (sfr_pkg::LEN_W'(gb) < fill_ext);
    end

    // Window plus new word reach the pattern length exactly when fill is plen-1.
    assign pass_all = (plen == '0) || (fill_ext >= plen);
    assign full     = !pass_all && ((fill_ext + sfr_pkg::LEN_W'(1)) == plen);
    assign match    = full && (c == pat_chars[fill_reg]) && (&(win_hit | ~win_below));

    always_comb begin
        do_shift  = 1'b0;
        do_append = 1'b0;
        use_rep   = 1'b0;
        res_cnt   = fill_ext + sfr_pkg::CNT_W'(1);
        fill_next = fill_reg;
        priority if (pass_all) begin
            fill_next = '0;
        end else if (match) begin
            use_rep   = 1'b1;
            res_cnt   = rlen;
            fill_next = '0;
        end else if (last) begin
            // Flush window and new word.
            fill_next = '0;
        end else if (full) begin
            // Emit the oldest, slide the rest down, park the new word at the top.
            do_shift  = 1'b1;
            res_cnt   = sfr_pkg::CNT_W'(1);
        end else begin
            do_append = 1'b1;
            res_cnt   = '0;
            fill_next = fill_reg + sfr_pkg::FILL_W'(1);
        end
    end

    // Nothing left to emit at end of message: send a bare end marker.
    assign bare = last && (res_cnt == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (s_acc) begin
            fill_reg <= fill_next;
        end
    end

    // ---------------------------------------------------------------- window cells
    for (genvar gw = 0; gw < sfr_pkg::WIN_DEPTH; gw++) begin : g_win
        sfr_pkg::win_ctl_t        wctl;
        logic [sfr_pkg::CP_W-1:0] right_char;

        assign wctl.shift  = s_acc && do_shift;
        assign wctl.take_c = s_acc &&
                             ((do_shift  && (fill_ext == sfr_pkg::LEN_W'(gw + 1))) ||
                              (do_append && (fill_ext == sfr_pkg::LEN_W'(gw))));

        if (gw + 1 < sfr_pkg::WIN_DEPTH) begin : g_mid
            assign right_char = win_chars[gw + 1];
        end else begin : g_end
            assign right_char = '0;
        end

        sfr_win_cell u_cell (
            .aclk       (aclk),
            .ctl        (wctl),
            .new_char   (c),
            .right_char (right_char),
            .pat_char   (pat_chars[gw]),
            .cell_char  (win_chars[gw]),
            .hit        (win_hit[gw])
        );
    end

    // ---------------------------------------------------------------- result cells
    logic [sfr_pkg::CNT_W-1:0] load_cnt;
    sfr_pkg::out_word_t        out_words [sfr_pkg::OUT_DEPTH];

    assign load_cnt = bare ? sfr_pkg::CNT_W'(1) : res_cnt;

    for (genvar go = 0; go < sfr_pkg::OUT_DEPTH; go++) begin : g_out
        sfr_pkg::out_ctl_t        octl;
        sfr_pkg::out_word_t       load_word;
        sfr_pkg::out_word_t       right_word;
        logic [sfr_pkg::CP_W-1:0] flush_char;

        // Flush list: window entries below fill, then the new word.
        if (go < sfr_pkg::WIN_DEPTH) begin : g_fw
            assign flush_char = win_below[go] ? win_chars[go] : c;
        end else begin : g_fc
            assign flush_char = c;
        end

        if (go + 1 < sfr_pkg::OUT_DEPTH) begin : g_mid
            assign right_word = out_words[go + 1];
        end else begin : g_end
            assign right_word = '0;
        end

        assign load_word.out_char       = bare    ? '0 :
                                          use_rep ? rep_chars[go] : flush_char;
        assign load_word.has_char       = !bare;
        assign load_word.end_of_message = last && (load_cnt == sfr_pkg::CNT_W'(go + 1));

        assign octl.load  = s_acc;
        assign octl.shift = m_acc;

        sfr_out_cell u_cell (
            .aclk       (aclk),
            .ctl        (octl),
            .load_word  (load_word),
            .right_word (right_word),
            .cell_word  (out_words[go])
        );
    end

    // Load the new burst on accept, else advance by one on each taken result.
    always_comb begin
        out_cnt_next = out_cnt_reg;
        if (s_acc) begin
            out_cnt_next = load_cnt;
        end else if (m_acc) begin
            out_cnt_next = out_cnt_reg - sfr_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_cnt_reg <= '0;
        end else begin
            out_cnt_reg <= out_cnt_next;
        end
    end

    assign m_data = out_words[0];

endmodule

### rtl/sfr_win_cell.sv
// One window cell: holds a character, compares it to its pattern character.
module sfr_win_cell (
    input  logic                   aclk,
    input  sfr_pkg::win_ctl_t      ctl,
    input  logic [sfr_pkg::CP_W-1:0] new_char,
    input  logic [sfr_pkg::CP_W-1:0] right_char,
    input  logic [sfr_pkg::CP_W-1:0] pat_char,
    output logic [sfr_pkg::CP_W-1:0] cell_char,
    output logic                   hit
);

    logic [sfr_pkg::CP_W-1:0] char_reg;
    logic [sfr_pkg::CP_W-1:0] char_next;

    always_comb begin
        char_next = char_reg;
        if (ctl.take_c) begin
            char_next = new_char;
        end else if (ctl.shift) begin
            char_next = right_char;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
    end

    assign cell_char = char_reg;
    assign hit       = (char_reg == pat_char);

endmodule

### rtl/sfr_out_cell.sv
// One result cell: loads a word in parallel or takes its neighbor's word.
module sfr_out_cell (
    input  logic               aclk,
    input  sfr_pkg::out_ctl_t  ctl,
    input  sfr_pkg::out_word_t load_word,
    input  sfr_pkg::out_word_t right_word,
    output sfr_pkg::out_word_t cell_word
);

    sfr_pkg::out_word_t word_reg;
    sfr_pkg::out_word_t word_next;

    always_comb begin
        word_next = word_reg;
        if (ctl.load) begin
            word_next = load_word;
        end else if (ctl.shift) begin
            word_next = right_word;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign cell_word = word_reg;

endmodule

### rtl/sfr_checker.sv
// Port-level checks for the find-and-replace unit, bound to the top level.
module sfr_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input sfr_pkg::out_word_t m_data
);

    // A stalled result word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // A word without a character is only the end marker.
    a_bare_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.has_char |-> m_data.end_of_message)
        else $error("bare word without end of message");

    a_bare_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.has_char |-> (m_data.out_char == '0))
        else $error("bare word carries a character value");

    // Input only stalls while results are pending.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no pending result");

endmodule

bind substring_find_replace_unit sfr_checker u_sfr_checker (.*);
